### rtl/lc3_instruction_step_core_macros.svh
// Assertion macros included by the step core RTL
`ifndef LC3_INSTRUCTION_STEP_CORE_MACROS_SVH
`define LC3_INSTRUCTION_STEP_CORE_MACROS_SVH
// Implication checked on every clock edge outside reset
`define LC3_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Implication checked in the cycle after the antecedent
`define LC3_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

### rtl/lc3_pkg.sv
// Package: payload types, codes and helpers of the LC-3 step core
`timescale 1ns / 1ps
package lc3_pkg;
  localparam int ADDR_BITS = 16;

  localparam logic [1:0] OP_EXEC = 2'd0;
  localparam logic [1:0] OP_MEM_WR = 2'd1;
  localparam logic [1:0] OP_REG_WR = 2'd2;
  localparam logic [1:0] OP_MEM_RD = 2'd3;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_HALT = 3'd1;
  localparam logic [2:0] ST_FETCH = 3'd2;
  localparam logic [2:0] ST_BAD_ENC = 3'd3;
  localparam logic [2:0] ST_RESERVED = 3'd4;
  localparam logic [2:0] ST_BAD_TRAP = 3'd5;
  localparam logic [2:0] ST_EMPTY = 3'd6;

  localparam logic [3:0] OPC_BR = 4'd0;
  localparam logic [3:0] OPC_ADD = 4'd1;
  localparam logic [3:0] OPC_LD = 4'd2;
  localparam logic [3:0] OPC_ST = 4'd3;
  localparam logic [3:0] OPC_JSR = 4'd4;
  localparam logic [3:0] OPC_AND = 4'd5;
  localparam logic [3:0] OPC_LDR = 4'd6;
  localparam logic [3:0] OPC_STR = 4'd7;
  localparam logic [3:0] OPC_NOT = 4'd9;
  localparam logic [3:0] OPC_LDI = 4'd10;
  localparam logic [3:0] OPC_STI = 4'd11;
  localparam logic [3:0] OPC_JMP = 4'd12;
  localparam logic [3:0] OPC_LEA = 4'd14;
  localparam logic [3:0] OPC_TRAP = 4'd15;

  localparam logic [7:0] TRAP_HALT = 8'h25;
  localparam logic [7:0] TRAP_CON_LO = 8'h20;
  localparam logic [7:0] TRAP_CON_HI = 8'h24;

  localparam logic [15:0] REG_PC = 16'd8;
  localparam logic [15:0] REG_CC = 16'd9;

  localparam logic [1:0] CFG_START_PC = 2'd0;
  localparam logic [1:0] CFG_FETCH_LOW = 2'd1;
  localparam logic [1:0] CFG_FETCH_LIMIT = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [15:0] addr;
    logic [15:0] data;
  } in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [15:0] next_pc;
    logic [15:0] read_data;
    logic [7:0] trap_vector;
  } out_t;

  function automatic logic [2:0] nzp(input logic [15:0] v);
    nzp = (v == 16'd0) ? 3'b010 : (v[15] ? 3'b100 : 3'b001);
  endfunction
endpackage

### rtl/lc3_instruction_step_core.sv
`timescale 1ns / 1ps
// LC-3 step core: register file, PC, flags and one synchronous word memory.
// Input channel in_valid/in_ready carries a word of type in_t: execute one
// instruction, write memory, write a register, or read memory.
// Output channel out_valid/out_ready returns one out_t word per input word.
// Configuration: cfg_we with cfg_index/cfg_data; write start_pc (also loads
// the PC), fetch_low or fetch_limit while the core is idle.
// Path from the accepting edge to the output register: a register write, a
// stopped core or a fetch violation goes straight to S_DONE; memory writes
// and reads and instructions without a data read (ST/STR write during
// decode) pass through S_FETCH; LD and LDR through S_FETCH and S_DATA; STI
// through S_FETCH and S_IND; LDI through S_FETCH, S_IND and S_DATA. Every
// memory access goes through the single memory port. A new item is taken
// only in S_IDLE, entered when the previous result is loaded for output.
// The output register is a single stage: while the receiver stalls, one
// result waits there and the next item runs but holds its result until the
// register frees.
// Reset clears registers, flags, stopped and loads the PC with 0x3000;
// memory contents are undefined until written.
`include "lc3_instruction_step_core_macros.svh"
module lc3_instruction_step_core (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  lc3_pkg::in_t in_word,
  output logic out_valid,
  input  logic out_ready,
  output lc3_pkg::out_t out_word,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data
);
  typedef enum logic [2:0] {S_IDLE, S_FETCH, S_IND, S_DATA, S_DONE} state_t;
  localparam int AW = lc3_pkg::ADDR_BITS;

  logic [15:0] mem [0:(1 << AW) - 1];
  logic [15:0] mem_q;
  logic mem_we;
  logic [AW-1:0] mem_addr;
  logic [15:0] mem_wd;

  state_t state;
  lc3_pkg::in_t cur;
  logic [15:0] regs [0:7];
  logic [15:0] pc, fetch_low, fetch_limit;
  logic [2:0] cc;
  logic stopped;
  logic [15:0] ir;
  logic [15:0] ea;
  lc3_pkg::out_t res;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end
    mem_q <= mem[mem_addr];
  end

  // decode of a freshly fetched word (mem_q in S_FETCH)
  logic [15:0] w;
  logic [3:0] opc;
  logic [2:0] dr, sr1;
  logic [15:0] pc1, off9, off11, off6, imm5, src2, sv1, alu, ra, pc_after;
  state_t fetch_next;
  assign w = mem_q;
  assign opc = w[15:12];
  assign dr = w[11:9];
  assign sr1 = w[8:6];
  assign pc1 = pc + 16'd1;
  assign off9 = {{7{w[8]}}, w[8:0]};
  assign off11 = {{5{w[10]}}, w[10:0]};
  assign off6 = {{10{w[5]}}, w[5:0]};
  assign imm5 = {{11{w[4]}}, w[4:0]};
  assign sv1 = regs[sr1];
  assign src2 = w[5] ? imm5 : regs[w[2:0]];
  assign alu = (opc == lc3_pkg::OPC_ADD) ? sv1 + src2 : sv1 & src2;
  assign ra = sv1 + off6;

  // PC after the fetched instruction and the state that follows decode
  always_comb begin
    pc_after = pc1;
    fetch_next = S_DONE;
    if (cur.op == lc3_pkg::OP_EXEC) begin
      case (opc)
        lc3_pkg::OPC_BR: begin
          if ((dr & cc) != 3'd0) begin
            pc_after = ea;
          end
        end
        lc3_pkg::OPC_JMP: begin
          if (dr == 3'd0 && w[5:0] == 6'd0) begin
            pc_after = sv1;
          end
        end
        lc3_pkg::OPC_JSR: begin
          if (w[11]) begin
            pc_after = pc1 + off11;
          end else if (dr == 3'd0 && w[5:0] == 6'd0) begin
            pc_after = sv1;
          end
        end
        lc3_pkg::OPC_TRAP: begin
          if (w[7:0] == lc3_pkg::TRAP_HALT) begin
            pc_after = 16'd0;
          end
        end
        lc3_pkg::OPC_LD, lc3_pkg::OPC_LDR: fetch_next = S_DATA;
        lc3_pkg::OPC_LDI, lc3_pkg::OPC_STI: fetch_next = S_IND;
        default: begin
        end
      endcase
    end
  end

  logic out_free;
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && !cfg_we;

  always_comb begin
    mem_we = 1'b0;
    mem_addr = cur.addr[AW-1:0];
    mem_wd = cur.data;
    if (state == S_IDLE) begin
      mem_addr = in_word.op == lc3_pkg::OP_EXEC ? pc[AW-1:0] : in_word.addr[AW-1:0];
      mem_wd = in_word.data;
      mem_we = in_valid && in_ready && in_word.op == lc3_pkg::OP_MEM_WR;
    end else if (state == S_FETCH) begin
      mem_addr = ea[AW-1:0];
      case (opc)
        lc3_pkg::OPC_LDR, lc3_pkg::OPC_STR: begin
          mem_addr = ra[AW-1:0];
        end
        default: begin
        end
      endcase
      mem_wd = regs[dr];
      mem_we = cur.op == lc3_pkg::OP_EXEC && !stopped &&
               (opc == lc3_pkg::OPC_ST || opc == lc3_pkg::OPC_STR);
    end else if (state == S_IND) begin
      mem_addr = mem_q[AW-1:0];
      mem_wd = regs[ir[11:9]];
      mem_we = ir[15:12] == lc3_pkg::OPC_STI;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        regs[i] <= 16'd0;
      end
      fetch_low <= 16'h3000;
      fetch_limit <= 16'hFE00;
      pc <= 16'h3000;
      cc <= 3'd0;
      stopped <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        out_word <= res;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          lc3_pkg::CFG_START_PC: pc <= cfg_data;
          lc3_pkg::CFG_FETCH_LOW: fetch_low <= cfg_data;
          lc3_pkg::CFG_FETCH_LIMIT: fetch_limit <= cfg_data;
          default: begin
          end
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            cur <= in_word;
            res.read_data <= 16'd0;
            res.trap_vector <= 8'd0;
            res.next_pc <= (in_word.op == lc3_pkg::OP_REG_WR &&
                            in_word.addr == lc3_pkg::REG_PC) ? in_word.data : pc;
            if (in_word.op == lc3_pkg::OP_REG_WR) begin
              res.status <= lc3_pkg::ST_OK;
              if (in_word.addr < 16'd8) begin
                regs[in_word.addr[2:0]] <= in_word.data;
              end else if (in_word.addr == lc3_pkg::REG_PC) begin
                pc <= in_word.data;
              end else if (in_word.addr == lc3_pkg::REG_CC) begin
                cc <= in_word.data[2:0];
              end
              state <= S_DONE;
            end else if (in_word.op == lc3_pkg::OP_EXEC) begin
              if (stopped) begin
                res.status <= lc3_pkg::ST_HALT;
                state <= S_DONE;
              end else if (pc < fetch_low || pc >= fetch_limit) begin
                res.status <= lc3_pkg::ST_FETCH;
                stopped <= 1'b1;
                state <= S_DONE;
              end else begin
                res.status <= lc3_pkg::ST_OK;
                state <= S_FETCH;
              end
            end else begin
              res.status <= lc3_pkg::ST_OK;
              state <= S_FETCH;
            end
          end
        end
        S_FETCH: begin
          state <= fetch_next;
          if (cur.op == lc3_pkg::OP_MEM_RD) begin
            res.read_data <= mem_q;
          end else if (cur.op == lc3_pkg::OP_EXEC) begin
            ir <= w;
            pc <= pc_after;
            res.next_pc <= (w == 16'd0) ? 16'd0 : pc_after;
            case (opc)
              lc3_pkg::OPC_ADD, lc3_pkg::OPC_AND: begin
                if (!w[5] && w[4:3] != 2'd0) begin
                  res.status <= lc3_pkg::ST_BAD_ENC;
                  stopped <= 1'b1;
                end else begin
                  regs[dr] <= alu;
                  cc <= lc3_pkg::nzp(alu);
                end
              end
              lc3_pkg::OPC_NOT: begin
                if (w[5:0] != 6'h3F) begin
                  res.status <= lc3_pkg::ST_BAD_ENC;
                  stopped <= 1'b1;
                end else begin
                  regs[dr] <= ~sv1;
                  cc <= lc3_pkg::nzp(~sv1);
                end
              end
              lc3_pkg::OPC_BR: begin
                if (w == 16'd0) begin
                  res.status <= lc3_pkg::ST_EMPTY;
                  stopped <= 1'b1;
                end
              end
              lc3_pkg::OPC_JMP: begin
                if (dr != 3'd0 || w[5:0] != 6'd0) begin
                  res.status <= lc3_pkg::ST_BAD_ENC;
                  stopped <= 1'b1;
                end
              end
              lc3_pkg::OPC_JSR: begin
                if (!w[11] && (dr != 3'd0 || w[5:0] != 6'd0)) begin
                  res.status <= lc3_pkg::ST_BAD_ENC;
                  stopped <= 1'b1;
                end else begin
                  regs[7] <= pc1;
                end
              end
              lc3_pkg::OPC_LEA: begin
                regs[dr] <= ea;
                cc <= lc3_pkg::nzp(ea);
              end
              lc3_pkg::OPC_LD, lc3_pkg::OPC_LDR, lc3_pkg::OPC_LDI, lc3_pkg::OPC_STI,
              lc3_pkg::OPC_ST, lc3_pkg::OPC_STR: begin
              end
              lc3_pkg::OPC_TRAP: begin
                if (w[7:0] == lc3_pkg::TRAP_HALT) begin
                  res.status <= lc3_pkg::ST_HALT;
                  stopped <= 1'b1;
                end else if (w[7:0] >= lc3_pkg::TRAP_CON_LO &&
                             w[7:0] <= lc3_pkg::TRAP_CON_HI) begin
                  res.trap_vector <= w[7:0];
                end else begin
                  res.status <= lc3_pkg::ST_BAD_TRAP;
                  stopped <= 1'b1;
                end
              end
              default: begin
                res.status <= lc3_pkg::ST_RESERVED;
                stopped <= 1'b1;
              end
            endcase
          end
        end
        S_IND: begin
          state <= (ir[15:12] == lc3_pkg::OPC_LDI) ? S_DATA : S_DONE;
        end
        S_DATA: begin
          regs[ir[11:9]] <= mem_q;
          cc <= lc3_pkg::nzp(mem_q);
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign ea = pc1 + off9;

  `LC3_ASSERT_IMP(a_ready_idle, in_ready, state == S_IDLE, "ready outside idle")
  `LC3_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word),
    "output word dropped while stalled")
  `LC3_ASSERT_IMP(a_no_wr_idle_busy, mem_we && state == S_IDLE,
    in_word.op == lc3_pkg::OP_MEM_WR, "stray memory write")
endmodule
